// ===== rtl/b5421_pkg.sv =====
// Package for the 5421-code decimal serial adder.
// Holds code constants, the code/digit conversion functions and the shared types.
// No dependencies.
package b5421_pkg;

  localparam int unsigned CODE_W     = 4;
  localparam int unsigned DIGIT_W    = 4;

  // 5421 codes of the digits five and nine bound the upper valid range
  localparam logic [CODE_W-1:0] CODE_FIVE   = 4'b1000;
  localparam logic [CODE_W-1:0] CODE_NINE   = 4'b1100;
  localparam logic [CODE_W-1:0] CODE_FOUR   = 4'b0100;
  localparam logic [CODE_W-1:0] CODE_ZERO   = 4'b0000;
  localparam logic [CODE_W-1:0] CODE_ONE    = 4'b0001;
  localparam logic [4:0]        FIX_ADD     = 5'd3;
  localparam logic [4:0]        DEC_BASE    = 5'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_FOUR = 4'd4;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

  // Result queue sizing
  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [CODE_W-1:0] sum_code;
    logic              carry_out;
  } digit_res_t;

  typedef struct packed {
    logic [CODE_W-1:0] sum_code;
    logic              final_digit;
  } res_entry_t;

  function automatic logic code_valid(input logic [CODE_W-1:0] c);
    return (c <= CODE_FOUR) || ((c >= CODE_FIVE) && (c <= CODE_NINE));
  endfunction

  // Invalid codes count as digit zero
  function automatic logic [DIGIT_W-1:0] code_to_digit(input logic [CODE_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    if (c <= CODE_FOUR) begin
      d = c;
    end else if ((c >= CODE_FIVE) && (c <= CODE_NINE)) begin
      d = c - DIGIT_W'(3);
    end else begin
      d = '0;
    end
    return d;
  endfunction

  function automatic logic [CODE_W-1:0] digit_to_code(input logic [DIGIT_W-1:0] d);
    logic [CODE_W-1:0] c;
    if (d <= DIGIT_FOUR) begin
      c = d;
    end else if (d <= DIGIT_NINE) begin
      c = d + CODE_W'(3);
    end else begin
      c = CODE_ZERO;
    end
    return c;
  endfunction

endpackage

// ===== rtl/b5421_if.sv =====
// Handshake channel interfaces for the 5421 serial adder.
// Operand channel carries one digit pair, result channel one sum digit.
// No dependencies.
interface b5421_operand_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [3:0] code_a;
  logic [3:0] code_b;
  logic       top_digit;

  modport source (output valid, output code_a, output code_b, output top_digit,
                  input ready);
  modport sink   (input valid, input code_a, input code_b, input top_digit,
                  output ready);
endinterface

interface b5421_result_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [3:0] sum_code;
  logic       final_digit;

  modport source (output valid, output sum_code, output final_digit, input ready);
  modport sink   (input valid, input sum_code, input final_digit, output ready);
endinterface

// ===== rtl/b5421_digit_add.sv =====
// One-digit 5421-code adder with +3 correction.
// Depends on b5421_pkg for code conversion functions and digit_res_t.
module b5421_digit_add (
  input  logic [3:0]             code_a,
  input  logic [3:0]             code_b,
  input  logic                   carry_in,
  output b5421_pkg::digit_res_t  res
);

  logic [3:0] da;
  logic [3:0] db;
  logic [4:0] raw;
  logic [4:0] fixed;
  logic [4:0] dsum;
  logic [4:0] want_d;
  logic       want_c;
  logic [3:0] nib;
  logic       keep_raw;

  // Decode operands, then add the re-encoded codes in binary
  assign da    = b5421_pkg::code_to_digit(code_a);
  assign db    = b5421_pkg::code_to_digit(code_b);
  assign raw   = {1'b0, b5421_pkg::digit_to_code(da)} +
                 {1'b0, b5421_pkg::digit_to_code(db)} + {4'b0, carry_in};
  assign fixed = raw + b5421_pkg::FIX_ADD;
  assign nib   = raw[3:0];

  // Decimal sum to check the raw nibble against
  assign dsum   = {1'b0, da} + {1'b0, db} + {4'b0, carry_in};
  assign want_c = (dsum >= b5421_pkg::DEC_BASE);
  assign want_d = want_c ? (dsum - b5421_pkg::DEC_BASE) : dsum;

  assign keep_raw = b5421_pkg::code_valid(nib) &&
                    ({1'b0, b5421_pkg::code_to_digit(nib)} == want_d) &&
                    (raw[4] == want_c);

  // Take the raw nibble where it is already right, else the corrected one
  always_comb begin
    if (keep_raw) begin
      res.sum_code  = nib;
      res.carry_out = raw[4];
    end else begin
      res.sum_code  = fixed[3:0];
      res.carry_out = fixed[4];
    end
  end

endmodule

// ===== rtl/bcd5421_serial_adder_top.sv =====
// Top level of the 5421-code decimal serial adder.
// Depends on b5421_pkg, b5421_if.sv (channel interfaces) and b5421_digit_add.
//
// Usage:
//   operand: one transaction per digit pair, code_a and code_b in 5421 code,
//            least significant digit first; top_digit marks the last pair.
//   result : one transaction per sum digit, least significant first;
//            final_digit marks the last digit of the sum. A top pair that
//            produces a carry yields two result transactions, the second
//            being code 0001.
// Timing: an accepted pair is held in the input register, then written to the
//   result queue. One operand is taken per cycle while operand ready is high;
//   the carry is resolved within the digit add stage.
// Results wait in an eight-entry queue. When the receiver stalls the queue
//   fills and operand ready drops once fewer than two free entries remain
//   after reserving room for the pair in the input register.
// Reset clears the carry, the input register valid and the queue; the block
//   is ready once reset is released.
module bcd5421_serial_adder_top (
  input  logic clk,
  input  logic rst,
  b5421_operand_if.sink   operand,
  b5421_result_if.source  result
);

  // Input register
  logic       s1_valid;
  logic [3:0] s1_code_a;
  logic [3:0] s1_code_b;
  logic       s1_top;

  logic       carry_bit;
  b5421_pkg::digit_res_t dres;

  // Result queue
  b5421_pkg::res_entry_t                queue [b5421_pkg::RES_DEPTH];
  logic [b5421_pkg::RES_PTR_W-1:0]      wr_ptr;
  logic [b5421_pkg::RES_PTR_W-1:0]      rd_ptr;
  logic [b5421_pkg::RES_CNT_W-1:0]      count;
  logic [b5421_pkg::RES_CNT_W-1:0]      count_next;
  logic [b5421_pkg::RES_CNT_W:0]        committed;

  logic       take;
  logic       pop;
  logic       push_one;
  logic       push_two;
  logic [1:0] push_n;

  // Accept while the queue has room for this pair and the one in flight
  assign committed = {1'b0, count} + (s1_valid ? (b5421_pkg::RES_CNT_W+1)'(2) : '0);
  assign operand.ready = (committed <= (b5421_pkg::RES_CNT_W+1)'(b5421_pkg::RES_DEPTH - 2));
  assign take = operand.valid && operand.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  // Hold the operand payload of the accepted transaction
  always_ff @(posedge clk) begin
    if (take) begin
      s1_code_a <= operand.code_a;
      s1_code_b <= operand.code_b;
      s1_top    <= operand.top_digit;
    end
  end

  b5421_digit_add u_digit_add (
    .code_a   (s1_code_a),
    .code_b   (s1_code_b),
    .carry_in (carry_bit),
    .res      (dres)
  );

  // Advance the carry; drop it after the top digit
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_bit <= 1'b0;
    end else if (s1_valid) begin
      carry_bit <= s1_top ? 1'b0 : dres.carry_out;
    end
  end

  assign push_one = s1_valid;
  assign push_two = s1_valid && s1_top && dres.carry_out;
  assign push_n   = {1'b0, push_one} + {1'b0, push_two};
  assign pop      = result.valid && result.ready;

  // Write the sum digit, and the extra carry digit after a top pair
  always_ff @(posedge clk) begin
    if (push_one) begin
      queue[wr_ptr] <= '{sum_code: dres.sum_code, final_digit: s1_top && !dres.carry_out};
    end
    if (push_two) begin
      queue[wr_ptr + b5421_pkg::RES_PTR_W'(1)] <= '{sum_code: b5421_pkg::CODE_ONE,
                                                    final_digit: 1'b1};
    end
  end

  assign count_next = count + {{(b5421_pkg::RES_CNT_W-2){1'b0}}, push_n}
                    - {{(b5421_pkg::RES_CNT_W-1){1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + {{(b5421_pkg::RES_PTR_W-2){1'b0}}, push_n};
      rd_ptr <= rd_ptr + {{(b5421_pkg::RES_PTR_W-1){1'b0}}, pop};
      count  <= count_next;
    end
  end

  assign result.valid       = (count != '0);
  assign result.sum_code    = queue[rd_ptr].sum_code;
  assign result.final_digit = queue[rd_ptr].final_digit;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= b5421_pkg::RES_CNT_W'(b5421_pkg::RES_DEPTH))
    else $error("result queue count beyond depth");

  a_room_in_flight: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (count <= b5421_pkg::RES_CNT_W'(b5421_pkg::RES_DEPTH - 2)))
    else $error("no room reserved for the pair in flight");

  a_carry_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_top) |=> !carry_bit)
    else $error("carry not cleared after top digit");

  a_two_only_top: assert property (@(posedge clk) disable iff (rst)
    push_two |-> (s1_top && dres.carry_out && push_one))
    else $error("extra digit pushed outside a carrying top pair");
`endif

endmodule
